>>> design/enveloped_sine_tone_burst_macros.svh
// assertion macros used by the tone burst top level
`ifndef ENVELOPED_SINE_TONE_BURST_MACROS_SVH
`define ENVELOPED_SINE_TONE_BURST_MACROS_SVH

// same-cycle implication on clock, disabled during reset
`define ESTB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tone burst assertion failed");

// next-cycle implication on clock, disabled during reset
`define ESTB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tone burst assertion failed");

// implication after a fixed number of cycles
`define ESTB_ASSERT_DELAY(label, ante, dly, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("tone burst assertion failed");

`endif

>>> design/estb_pkg.sv
// shared constants, types and sine table of the tone burst generator
package estb_pkg;

   // sizing
   localparam int PHASE_BITS      = 32;
   localparam int SINE_INDEX_BITS = 10;
   localparam int SAMPLE_BITS     = 16;

   localparam int QUARTER_BITS = SINE_INDEX_BITS - 2;
   localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
   localparam int QADDR_W      = QUARTER_BITS + 1;

   // fixed field widths
   localparam int STEP_W      = 32;
   localparam int GAIN_W      = 17;
   localparam int CURSOR_W    = 16;
   localparam int RECIP_W     = 17;
   localparam int ENV_W       = 17;
   localparam int SINE_W      = 15;
   localparam int SAMPLE_W    = 16;
   localparam int ENV_PROD_W  = CURSOR_W + RECIP_W;
   localparam int GAIN_PROD_W = SINE_W + GAIN_W;
   localparam int FULL_W      = GAIN_PROD_W + ENV_W;
   localparam int MAG_SHIFT   = 48 - SAMPLE_BITS;
   localparam int MAG_W       = FULL_W - MAG_SHIFT;
   localparam int SAT_W       = SAMPLE_BITS - 1;
   localparam int EXT_W       = SAMPLE_BITS + SAMPLE_W;

   localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);
   localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'((64'd1 << SAT_W) - 64'd1);

   // port widths
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_USER_W  = 1;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_TONE_GAIN    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_BURST_FRAMES = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_FRAMES  = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_FRAMES = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_RECIP   = CSR_INDEX_W'(5);
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_RECIP  = CSR_INDEX_W'(6);

   // register reset values
   localparam logic [STEP_W-1:0]   RST_PHASE_STEP     = STEP_W'(157482134);
   localparam logic [GAIN_W-1:0]   RST_TONE_GAIN      = GAIN_W'(19661);
   localparam logic [CURSOR_W-1:0] RST_BURST_FRAMES   = CURSOR_W'(2160);
   localparam logic [CURSOR_W-1:0] RST_ATTACK_FRAMES  = CURSOR_W'(192);
   localparam logic [CURSOR_W-1:0] RST_RELEASE_FRAMES = CURSOR_W'(864);
   localparam logic [RECIP_W-1:0]  RST_ATTACK_RECIP   = RECIP_W'(341);
   localparam logic [RECIP_W-1:0]  RST_RELEASE_RECIP  = RECIP_W'(76);

   // sine polynomial coefficients
   localparam longint unsigned POLY_A = 102944;
   localparam longint unsigned POLY_B = 42334;
   localparam longint unsigned POLY_C = 4926;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic env_en;
      logic gain_en;
      logic scale_en;
      logic emit_en;
   } estb_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } estb_status_type;

   // quarter wave magnitude table, one entry per quadrant index including the peak
   typedef logic [SINE_W-1:0] sine_rom_type [0:QUARTER_LEN];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned y;
      for (int i = 0; i <= QUARTER_LEN; i++) begin
         x  = longint'(i) << (16 - QUARTER_BITS);
         x2 = (x * x) >> 16;
         t  = (POLY_C * x2) >> 16;
         t  = POLY_B - t;
         t  = (t * x2) >> 16;
         t  = POLY_A - t;
         y  = ((x * t) >> 16) >> 1;
         if (y > 64'd32767) begin
            y = 64'd32767;
         end
         rom[i] = SINE_W'(y);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

>>> design/estb_ctrl.sv
// sequencing controller: accepts a frame word and steps the datapath through its stages
module estb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  estb_pkg::estb_status_type status,
   output estb_pkg::estb_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENV,
      ST_GAIN,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;
   logic      accept;

   assign accept = req_tvalid && ready_ff;

   // next state and ready
   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ENV;
               ready_in = 1'b0;
            end
         end
         ST_ENV: begin
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   // stage enables
   always_comb begin
      cmd.accept   = accept;
      cmd.env_en   = (state_ff == ST_ENV);
      cmd.gain_en  = (state_ff == ST_GAIN);
      cmd.scale_en = (state_ff == ST_SCALE);
      cmd.emit_en  = (state_ff == ST_EMIT) && status.out_free;
   end

   assign req_tready = ready_ff;

endmodule

>>> design/estb_datapath.sv
// datapath: control registers, phase and cursor, envelope, sine table, scaling, output word
module estb_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [estb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [estb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                start_req,
   input  estb_pkg::estb_cmd_type              cmd,
   output estb_pkg::estb_status_type           status,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [estb_pkg::SAMPLE_W-1:0]       sample,
   output logic                                active
);

   // control registers
   logic [estb_pkg::STEP_W-1:0]   phase_step_ff,   phase_step_in;
   logic [estb_pkg::GAIN_W-1:0]   tone_gain_ff,    tone_gain_in;
   logic [estb_pkg::CURSOR_W-1:0] burst_ff,        burst_in;
   logic [estb_pkg::CURSOR_W-1:0] attack_ff,       attack_in;
   logic [estb_pkg::CURSOR_W-1:0] release_ff,      release_in;
   logic [estb_pkg::RECIP_W-1:0]  attack_recip_ff, attack_recip_in;
   logic [estb_pkg::RECIP_W-1:0]  release_recip_ff, release_recip_in;

   // oscillator state
   logic [estb_pkg::PHASE_BITS-1:0] phase_ff,  phase_in;
   logic [estb_pkg::CURSOR_W-1:0]   cursor_ff, cursor_in;

   // per-frame work registers
   logic [estb_pkg::SINE_INDEX_BITS-1:0] idx_ff,      idx_in;
   logic [estb_pkg::CURSOR_W-1:0]        wcursor_ff,  wcursor_in;
   logic                                 wactive_ff,  wactive_in;
   logic [estb_pkg::ENV_PROD_W-1:0]      env_prod_ff, env_prod_in;
   logic                                 env_unity_ff, env_unity_in;
   logic [estb_pkg::SINE_W-1:0]          sine_ff,     sine_in;
   logic                                 neg_ff,      neg_in;
   logic [estb_pkg::ENV_W-1:0]           env_ff,      env_in;
   logic [estb_pkg::GAIN_PROD_W-1:0]     sg_ff,       sg_in;
   logic [estb_pkg::FULL_W-1:0]          full_ff,     full_in;

   // output word register
   logic                          out_valid_ff,  out_valid_in;
   logic [estb_pkg::SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                          out_active_ff, out_active_in;

   // combinational helpers
   logic [estb_pkg::CURSOR_W-1:0]    cursor_eff;
   logic                             frame_active;
   logic [estb_pkg::CURSOR_W:0]      rel_sum;
   logic                             in_attack;
   logic                             in_release;
   logic [estb_pkg::CURSOR_W-1:0]    env_op_a;
   logic [estb_pkg::RECIP_W-1:0]     env_op_b;
   logic [1:0]                       quad;
   logic [estb_pkg::QADDR_W-1:0]     qaddr;
   logic [estb_pkg::MAG_W-1:0]       mag;
   logic [estb_pkg::SAT_W-1:0]       mag_sat;
   logic [estb_pkg::EXT_W-1:0]       mag_ext;
   logic [estb_pkg::EXT_W-1:0]       signed_val;

   // register writes
   always_comb begin
      phase_step_in    = phase_step_ff;
      tone_gain_in     = tone_gain_ff;
      burst_in         = burst_ff;
      attack_in        = attack_ff;
      release_in       = release_ff;
      attack_recip_in  = attack_recip_ff;
      release_recip_in = release_recip_ff;
      if (csr_we) begin
         case (csr_index)
            estb_pkg::REG_PHASE_STEP:     phase_step_in = csr_wdata[estb_pkg::STEP_W-1:0];
            estb_pkg::REG_TONE_GAIN:      tone_gain_in  = csr_wdata[estb_pkg::GAIN_W-1:0];
            estb_pkg::REG_BURST_FRAMES:   burst_in      = csr_wdata[estb_pkg::CURSOR_W-1:0];
            estb_pkg::REG_ATTACK_FRAMES:  attack_in     = csr_wdata[estb_pkg::CURSOR_W-1:0];
            estb_pkg::REG_RELEASE_FRAMES: release_in    = csr_wdata[estb_pkg::CURSOR_W-1:0];
            estb_pkg::REG_ATTACK_RECIP: begin
               attack_recip_in = csr_wdata[estb_pkg::RECIP_W-1:0];
            end
            estb_pkg::REG_RELEASE_RECIP: begin
               release_recip_in = csr_wdata[estb_pkg::RECIP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // frame accept: restart, activity check, phase and cursor advance
   assign cursor_eff   = start_req ? '0 : cursor_ff;
   assign frame_active = (cursor_eff < burst_ff);

   always_comb begin
      phase_in   = phase_ff;
      cursor_in  = cursor_ff;
      idx_in     = idx_ff;
      wcursor_in = wcursor_ff;
      wactive_in = wactive_ff;
      if (cmd.accept) begin
         idx_in     = phase_ff[estb_pkg::PHASE_BITS-1 -: estb_pkg::SINE_INDEX_BITS];
         wcursor_in = cursor_eff;
         wactive_in = frame_active;
         cursor_in  = frame_active ? cursor_eff + 1'b1 : cursor_eff;
         if (frame_active) begin
            phase_in = phase_ff + estb_pkg::PHASE_BITS'(phase_step_ff);
         end
      end
   end

   // envelope segment select and ramp multiply
   assign rel_sum    = {1'b0, wcursor_ff} + {1'b0, release_ff};
   assign in_attack  = (wcursor_ff < attack_ff);
   assign in_release = (rel_sum >= {1'b0, burst_ff});

   always_comb begin
      if (in_attack) begin
         env_op_a = wcursor_ff;
         env_op_b = attack_recip_ff;
      end else begin
         env_op_a = burst_ff - wcursor_ff;
         env_op_b = release_recip_ff;
      end
   end

   // quarter wave address, mirrored in odd quadrants
   assign quad  = idx_ff[estb_pkg::SINE_INDEX_BITS-1 -: 2];
   always_comb begin
      if (quad[0]) begin
         qaddr = estb_pkg::QADDR_W'(estb_pkg::QUARTER_LEN)
               - {1'b0, idx_ff[estb_pkg::QUARTER_BITS-1:0]};
      end else begin
         qaddr = {1'b0, idx_ff[estb_pkg::QUARTER_BITS-1:0]};
      end
   end

   // stage next values
   always_comb begin
      env_prod_in  = env_prod_ff;
      env_unity_in = env_unity_ff;
      sine_in      = sine_ff;
      neg_in       = neg_ff;
      env_in       = env_ff;
      sg_in        = sg_ff;
      full_in      = full_ff;
      if (cmd.env_en) begin
         env_prod_in  = env_op_a * env_op_b;
         env_unity_in = !in_attack && !in_release;
         sine_in      = estb_pkg::SINE_ROM[qaddr];
         neg_in       = quad[1];
      end
      if (cmd.gain_en) begin
         if (env_unity_ff || (env_prod_ff > estb_pkg::ENV_PROD_W'(estb_pkg::ENV_ONE))) begin
            env_in = estb_pkg::ENV_ONE;
         end else begin
            env_in = env_prod_ff[estb_pkg::ENV_W-1:0];
         end
         sg_in = sine_ff * tone_gain_ff;
      end
      if (cmd.scale_en) begin
         full_in = sg_ff * env_ff;
      end
   end

   // saturate and apply the half wave sign
   assign mag = full_ff[estb_pkg::FULL_W-1:estb_pkg::MAG_SHIFT];
   always_comb begin
      if (mag > estb_pkg::MAG_LIMIT) begin
         mag_sat = '1;
      end else begin
         mag_sat = mag[estb_pkg::SAT_W-1:0];
      end
   end
   assign mag_ext    = estb_pkg::EXT_W'(mag_sat);
   assign signed_val = neg_ff ? (~mag_ext + 1'b1) : mag_ext;

   // output word register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_active_in = out_active_ff;
      if (cmd.emit_en) begin
         out_valid_in  = 1'b1;
         out_sample_in = wactive_ff ? signed_val[estb_pkg::SAMPLE_W-1:0] : '0;
         out_active_in = wactive_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= estb_pkg::RST_PHASE_STEP;
         tone_gain_ff     <= estb_pkg::RST_TONE_GAIN;
         burst_ff         <= estb_pkg::RST_BURST_FRAMES;
         attack_ff        <= estb_pkg::RST_ATTACK_FRAMES;
         release_ff       <= estb_pkg::RST_RELEASE_FRAMES;
         attack_recip_ff  <= estb_pkg::RST_ATTACK_RECIP;
         release_recip_ff <= estb_pkg::RST_RELEASE_RECIP;
         phase_ff         <= '0;
         cursor_ff        <= estb_pkg::RST_BURST_FRAMES;
         out_valid_ff     <= 1'b0;
      end else begin
         phase_step_ff    <= phase_step_in;
         tone_gain_ff     <= tone_gain_in;
         burst_ff         <= burst_in;
         attack_ff        <= attack_in;
         release_ff       <= release_in;
         attack_recip_ff  <= attack_recip_in;
         release_recip_ff <= release_recip_in;
         phase_ff         <= phase_in;
         cursor_ff        <= cursor_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      wcursor_ff    <= wcursor_in;
      wactive_ff    <= wactive_in;
      env_prod_ff   <= env_prod_in;
      env_unity_ff  <= env_unity_in;
      sine_ff       <= sine_in;
      neg_ff        <= neg_in;
      env_ff        <= env_in;
      sg_ff         <= sg_in;
      full_ff       <= full_in;
      out_sample_ff <= out_sample_in;
      out_active_ff <= out_active_in;
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign sample          = out_sample_ff;
   assign active          = out_active_ff;

endmodule

>>> design/enveloped_sine_tone_burst.sv
// top level of the enveloped sine tone burst generator
// a frame word is accepted only in the idle state; no further word is taken until the result
// word has been loaded, after the controller's stage sequence
// (envelope and table read, gain multiply, envelope multiply, output load)
// a stalled result holds the output load stage until the word is taken
// reset is synchronous: registers to defaults, phase to zero, cursor idle at burst length
module enveloped_sine_tone_burst (
   input  logic                                 clock,
   input  logic                                 reset,
   // frame words in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [estb_pkg::REQ_DATA_W-1:0]      req_tdata,   // [0] start_req, rest zero
   // sample words out
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [estb_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [15:0] sample
   output logic [estb_pkg::RSP_USER_W-1:0]      rsp_tuser,   // [0] active
   // register writes
   input  logic                                 csr_we,
   input  logic [estb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [estb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

`include "enveloped_sine_tone_burst_macros.svh"

   estb_pkg::estb_cmd_type    cmd;
   estb_pkg::estb_status_type status;
   logic                      active;

   // sequencing
   estb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic and state
   estb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .start_req  (req_tdata[0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .sample     (rsp_tdata),
      .active     (active)
   );

   assign rsp_tuser = active;

   // no second word taken while one is in the stages
   `ESTB_ASSERT_NEXT(busy_after_accept_a, req_tvalid && req_tready, !req_tready)
   // idle frames carry a silent sample
   `ESTB_ASSERT_IMP(silent_idle_word_a, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)
   // a result word is pending once the stages have run
   `ESTB_ASSERT_DELAY(result_follows_a, req_tvalid && req_tready, 5, rsp_tvalid)

endmodule

>>> tb/sv/tb_enveloped_sine_tone_burst.sv
// testbench for the enveloped sine tone burst generator: scoreboard, stream drivers, checks
`timescale 1ns / 100ps

module tb_enveloped_sine_tone_burst;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int MAX_IDLE      = 18;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_FRAMES = 1900;
   localparam int REPORT_CAP    = 100;
   localparam longint unsigned SAMPLE_MAX = (64'd1 << (estb_pkg::SAMPLE_BITS - 1)) - 64'd1;

   // indexes outside the register map, writes there must be ignored
   localparam logic [estb_pkg::CSR_INDEX_W-1:0] REG_UNUSED = estb_pkg::CSR_INDEX_W'(7);
   localparam logic [estb_pkg::CSR_INDEX_W-1:0] REG_TOP    = estb_pkg::CSR_INDEX_W'(255);

   // one result word as the block should present it
   typedef struct {
      logic [estb_pkg::SAMPLE_W-1:0] sample;
      logic                          active;
   } tone_word_type;

   // tone burst predictor and queue of expected sample words
   class tone_scoreboard;
      logic [estb_pkg::STEP_W-1:0]     step;
      logic [estb_pkg::GAIN_W-1:0]     gain;
      logic [estb_pkg::CURSOR_W-1:0]   burst_len;
      logic [estb_pkg::CURSOR_W-1:0]   attack_len;
      logic [estb_pkg::CURSOR_W-1:0]   rel_len;
      logic [estb_pkg::RECIP_W-1:0]    attack_slope;
      logic [estb_pkg::RECIP_W-1:0]    rel_slope;
      logic [estb_pkg::PHASE_BITS-1:0] phase;
      logic [estb_pkg::CURSOR_W-1:0]   cursor;
      tone_word_type                   expected_words[$];
      int                              errors;

      function void load_defaults();
         step         = estb_pkg::RST_PHASE_STEP;
         gain         = estb_pkg::RST_TONE_GAIN;
         burst_len    = estb_pkg::RST_BURST_FRAMES;
         attack_len   = estb_pkg::RST_ATTACK_FRAMES;
         rel_len      = estb_pkg::RST_RELEASE_FRAMES;
         attack_slope = estb_pkg::RST_ATTACK_RECIP;
         rel_slope    = estb_pkg::RST_RELEASE_RECIP;
         phase        = '0;
         cursor       = estb_pkg::RST_BURST_FRAMES;
         errors       = 0;
         expected_words.delete();
      endfunction

      function void write_reg(logic [estb_pkg::CSR_INDEX_W-1:0] index,
                              logic [estb_pkg::CSR_DATA_W-1:0] value);
         case (index)
            estb_pkg::REG_PHASE_STEP:     step         = value[estb_pkg::STEP_W-1:0];
            estb_pkg::REG_TONE_GAIN:      gain         = value[estb_pkg::GAIN_W-1:0];
            estb_pkg::REG_BURST_FRAMES:   burst_len    = value[estb_pkg::CURSOR_W-1:0];
            estb_pkg::REG_ATTACK_FRAMES:  attack_len   = value[estb_pkg::CURSOR_W-1:0];
            estb_pkg::REG_RELEASE_FRAMES: rel_len      = value[estb_pkg::CURSOR_W-1:0];
            estb_pkg::REG_ATTACK_RECIP:   attack_slope = value[estb_pkg::RECIP_W-1:0];
            estb_pkg::REG_RELEASE_RECIP:  rel_slope    = value[estb_pkg::RECIP_W-1:0];
            default: ;
         endcase
      endfunction

      // quarter wave polynomial at the top index bits of the phase
      function logic [estb_pkg::SINE_W-1:0] sine_magnitude(output bit negative);
         logic [estb_pkg::SINE_INDEX_BITS-1:0] idx;
         longint unsigned q, x, x2, t, y;
         idx = phase[estb_pkg::PHASE_BITS-1 -: estb_pkg::SINE_INDEX_BITS];
         q   = idx[estb_pkg::QUARTER_BITS-1:0];
         if (idx[estb_pkg::QUARTER_BITS]) begin
            q = estb_pkg::QUARTER_LEN - q;
         end
         x  = q << (16 - estb_pkg::QUARTER_BITS);
         x2 = (x * x) >> 16;
         t  = (estb_pkg::POLY_C * x2) >> 16;
         t  = estb_pkg::POLY_B - t;
         t  = (t * x2) >> 16;
         t  = estb_pkg::POLY_A - t;
         y  = ((x * t) >> 16) >> 1;
         if (y > 64'd32767) begin
            y = 64'd32767;
         end
         negative = idx[estb_pkg::QUARTER_BITS+1];
         return estb_pkg::SINE_W'(y);
      endfunction

      // one accepted frame word: work out its sample and advance the oscillator
      function void note_frame(bit start);
         tone_word_type                 w;
         longint unsigned               env;
         longint unsigned               mag;
         logic [estb_pkg::SINE_W-1:0]   s;
         bit                            negative;
         if (start) begin
            cursor = '0;
         end
         if (cursor >= burst_len) begin
            w.sample = '0;
            w.active = 1'b0;
         end else begin
            if (cursor < attack_len) begin
               env = 64'(cursor) * 64'(attack_slope);
            end else if (32'(cursor) + 32'(rel_len) >= 32'(burst_len)) begin
               env = 64'(burst_len - cursor) * 64'(rel_slope);
            end else begin
               env = 64'(estb_pkg::ENV_ONE);
            end
            if (env > 64'(estb_pkg::ENV_ONE)) begin
               env = 64'(estb_pkg::ENV_ONE);
            end
            s   = sine_magnitude(negative);
            mag = (64'(s) * 64'(gain) * env) >> estb_pkg::MAG_SHIFT;
            if (mag > SAMPLE_MAX) begin
               mag = SAMPLE_MAX;
            end
            if (negative) begin
               mag = -mag;
            end
            w.sample = mag[estb_pkg::SAMPLE_W-1:0];
            w.active = 1'b1;
            phase    = phase + step;
            cursor   = cursor + 1'b1;
         end
         expected_words.push_back(w);
      endfunction

      // compare one accepted sample word with the oldest expectation
      function void check_sample(logic [estb_pkg::SAMPLE_W-1:0] sample, logic active);
         tone_word_type w;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP) begin
               $display("%0t: sample word with none expected: actual sample %0d active %0b",
                        $time, $signed(sample), active);
            end
            return;
         end
         w = expected_words.pop_front();
         if (sample !== w.sample) begin
            errors++;
            if (errors <= REPORT_CAP) begin
               $display("%0t: sample mismatch: expected %0d, actual %0d",
                        $time, $signed(w.sample), $signed(sample));
            end
         end
         if (active !== w.active) begin
            errors++;
            if (errors <= REPORT_CAP) begin
               $display("%0t: active mismatch: expected %0b, actual %0b",
                        $time, w.active, active);
            end
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [estb_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [estb_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [estb_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                             csr_we;
   logic [estb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [estb_pkg::CSR_DATA_W-1:0]  csr_wdata;

   tone_scoreboard sb;
   bit             req_idle_on;
   bit             rsp_idle_on;
   int             frames_sent;
   int             cycle_count;

   enveloped_sine_tone_burst u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [0] start_req, rest zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] sample
      .rsp_tuser  (rsp_tuser),    // [0] active
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // sample word receiver with random stalls
   initial begin
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_sample(rsp_tdata, rsp_tuser[0]);
      end
   end

   // one frame word, after a random gap when the sender idles
   task automatic send_frame(input bit start);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= estb_pkg::REQ_DATA_W'(start);
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_frame(start);
      frames_sent++;
   endtask

   // register write, write enable left high for back to back writes
   task automatic write_reg(input logic [estb_pkg::CSR_INDEX_W-1:0] index,
                            input logic [estb_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic load_config(input logic [estb_pkg::CSR_DATA_W-1:0] step, gain, burst,
                              input logic [estb_pkg::CSR_DATA_W-1:0] attack_len, rel_len,
                              input logic [estb_pkg::CSR_DATA_W-1:0] attack_slope, rel_slope);
      write_reg(estb_pkg::REG_PHASE_STEP, step);
      write_reg(estb_pkg::REG_TONE_GAIN, gain);
      write_reg(estb_pkg::REG_BURST_FRAMES, burst);
      write_reg(estb_pkg::REG_ATTACK_FRAMES, attack_len);
      write_reg(estb_pkg::REG_RELEASE_FRAMES, rel_len);
      write_reg(estb_pkg::REG_ATTACK_RECIP, attack_slope);
      write_reg(estb_pkg::REG_RELEASE_RECIP, rel_slope);
      csr_we <= 1'b0;
   endtask

   // stop sending and let every expected sample word come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random settings, mostly short bursts so that every envelope region is reached
   task automatic random_config();
      logic [estb_pkg::CSR_DATA_W-1:0] step, gain, burst, attack_len, rel_len;
      logic [estb_pkg::CSR_DATA_W-1:0] attack_slope, rel_slope;
      case ($urandom_range(0, 5))
         0:       step = '0;
         1:       step = '1;
         2:       step = $urandom_range(0, 1 << 22);
         default: step = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0:       gain = '0;
         1:       gain = 65536;
         2:       gain = $urandom;
         3:       gain = $urandom_range(65537, 131071);
         default: gain = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 19))
         0:       burst = 0;
         1:       burst = 65535;
         2, 3:    burst = $urandom_range(50, 300);
         default: burst = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 9))
         0:       attack_len = 0;
         1:       attack_len = 65535;
         default: attack_len = $urandom_range(0, burst > 60 ? 60 : burst);
      endcase
      case ($urandom_range(0, 9))
         0:       rel_len = 0;
         1:       rel_len = 65535;
         default: rel_len = $urandom_range(0, burst > 60 ? 60 : burst);
      endcase
      attack_slope = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                 : 65536 / (attack_len == 0 ? 1 : attack_len);
      rel_slope    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                 : 65536 / (rel_len == 0 ? 1 : rel_len);
      if ($urandom_range(0, 3) == 0) begin
         write_reg($urandom_range(0, 1) ? REG_UNUSED : REG_TOP, $urandom);
      end
      load_config(step, gain, burst, attack_len, rel_len, attack_slope, rel_slope);
   endtask

   // main sequence
   initial begin
      int target;
      int count;
      int phases;
      sb = new;
      sb.load_defaults();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      frames_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle frames straight out of reset, cursor sits at the burst length
      send_frame(1'b0);
      send_frame(1'b0);
      wait_idle();

      // quarter turn steps through all quadrants, short burst with both ramps, then idle
      load_config(32'h4000_0000, 65536, 12, 3, 4, 21845, 16384);
      send_frame(1'b1);
      repeat (13) send_frame(1'b0);
      wait_idle();

      // gain above unity saturates, no ramps, largest phase step
      load_config('1, 131071, 4, 0, 0, 65536, 65536);
      send_frame(1'b1);
      repeat (4) send_frame(1'b0);
      wait_idle();

      // writes outside the register map, then an empty burst
      write_reg(REG_UNUSED, '1);
      write_reg(REG_TOP, 32'h1234_5678);
      load_config('0, 65536, 0, 0, 0, 0, 0);
      send_frame(1'b1);
      send_frame(1'b0);
      wait_idle();

      // random settings, each followed by bursts with random restarts
      target = frames_sent + RANDOM_FRAMES;
      phases = 0;
      while (frames_sent < target) begin
         random_config();
         case ($urandom_range(0, 3))
            0: begin req_idle_on = 1'b1; rsp_idle_on = 1'b1; end
            1: begin req_idle_on = 1'b0; rsp_idle_on = 1'b0; end
            2: begin req_idle_on = 1'b1; rsp_idle_on = 1'b0; end
            default: begin req_idle_on = 1'b0; rsp_idle_on = 1'b1; end
         endcase
         count = $urandom_range(40, 160);
         for (int i = 0; i < count; i++) begin
            // at mid burst, in the first phase and at random later, the sender holds off until the pipeline is empty
            if (i == count / 2 && (phases == 0 || $urandom_range(0, 3) == 0)) begin
               wait_idle();
            end
            send_frame(i == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0));
         end
         wait_idle();
         phases++;
      end

      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/estb_pkg.sv
design/estb_ctrl.sv
design/estb_datapath.sv
design/enveloped_sine_tone_burst.sv
tb/sv/tb_enveloped_sine_tone_burst.sv
